FILE: design/rilp_pkg.sv
package rilp_pkg;

  // literal kind codes
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_DEC      = 3'd0;
  localparam kind_t KIND_HEX      = 3'd1;
  localparam kind_t KIND_BIN      = 3'd2;
  localparam kind_t KIND_OCT      = 3'd3;
  localparam kind_t KIND_DEC_EXPL = 3'd4;

  // parse status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_INVALID  = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;
  localparam status_t ST_NONINT   = 2'd3;

  // overflow guards and decimal limit
  localparam logic [63:0] HEX_GUARD = 64'hF000_0000_0000_0000;
  localparam logic [63:0] BIN_GUARD = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OCT_GUARD = 64'hE000_0000_0000_0000;
  localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

  // character codes
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_5   = 8'h35;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_E   = 8'h65;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_O   = 8'h6F;
  localparam logic [7:0] CH_D   = 8'h64;
  localparam logic [7:0] CH_DOT = 8'h2E;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    status_t     status;
  } result_t;

  // error priority: invalid over non-integer over overflow
  function automatic status_t raise_err(input status_t cur, input status_t e);
    status_t r;
    r = cur;
    if (e == ST_INVALID) begin
      r = ST_INVALID;
    end else if (e == ST_NONINT && cur != ST_INVALID) begin
      r = ST_NONINT;
    end else if (e == ST_OVERFLOW && cur == ST_OK) begin
      r = ST_OVERFLOW;
    end
    return r;
  endfunction

endpackage

FILE: design/rilp_in_stage.sv
module rilp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  input  logic               adv,
  output logic               item_valid,
  output rilp_pkg::in_item_t item
);

  logic               valid_r;
  rilp_pkg::in_item_t item_r;
  logic               take;

  // hold the registered character until the core consumes it
  assign in_stall   = valid_r && !adv;
  assign take       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.char_code <= in_char_code;
      item_r.last_char <= in_last_char;
    end
  end

endmodule

FILE: design/rilp_core.sv
module rilp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  rilp_pkg::in_item_t item,
  input  logic               out_free,
  output logic               adv,
  output logic               fire,
  output rilp_pkg::result_t  res
);

  logic [63:0]       acc_r, acc_nxt;
  logic [1:0]        pos_r, pos_nxt;
  rilp_pkg::kind_t   mode_r, mode_nxt;
  logic [7:0]        first_r, first_nxt;
  rilp_pkg::status_t err_r, err_nxt;

  logic [7:0]  c;
  logic        is_dec, is_hexl, is_prefix;
  logic [3:0]  dval;
  logic [63:0] acc_x10;

  assign c = item.char_code;

  // digit classification
  assign is_dec  = (c >= rilp_pkg::CH_0) && (c <= rilp_pkg::CH_9);
  assign is_hexl = (c >= rilp_pkg::CH_A) && (c <= rilp_pkg::CH_F);
  assign dval    = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

  // times ten as two shifts and one add
  assign acc_x10 = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};

  // prefix recognition on the second character
  assign is_prefix = (pos_r == 2'd1) && (first_r == rilp_pkg::CH_0) &&
                     (mode_r == rilp_pkg::KIND_DEC) && (err_r == rilp_pkg::ST_OK) &&
                     (c == rilp_pkg::CH_X || c == rilp_pkg::CH_B ||
                      c == rilp_pkg::CH_O || c == rilp_pkg::CH_D);

  // per-character step
  always_comb begin
    acc_nxt   = acc_r;
    mode_nxt  = mode_r;
    err_nxt   = err_r;
    first_nxt = (pos_r == 2'd0) ? c : first_r;
    pos_nxt   = (pos_r == 2'd3) ? pos_r : 2'(pos_r + 2'd1);
    if (is_prefix) begin
      acc_nxt = '0;
      case (c)
        rilp_pkg::CH_X: mode_nxt = rilp_pkg::KIND_HEX;
        rilp_pkg::CH_B: mode_nxt = rilp_pkg::KIND_BIN;
        rilp_pkg::CH_O: mode_nxt = rilp_pkg::KIND_OCT;
        default:        mode_nxt = rilp_pkg::KIND_DEC_EXPL;
      endcase
    end else begin
      case (mode_r)
        rilp_pkg::KIND_HEX: begin
          if (is_dec || is_hexl) begin
            if (err_r == rilp_pkg::ST_OK) begin
              if ((acc_r & rilp_pkg::HEX_GUARD) != '0) begin
                err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_OVERFLOW);
              end else begin
                acc_nxt = {acc_r[59:0], dval};
              end
            end
          end else begin
            err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_INVALID);
          end
        end
        rilp_pkg::KIND_BIN: begin
          if (c == rilp_pkg::CH_0 || c == rilp_pkg::CH_1) begin
            if (err_r == rilp_pkg::ST_OK) begin
              if ((acc_r & rilp_pkg::BIN_GUARD) != '0) begin
                err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_OVERFLOW);
              end else begin
                acc_nxt = {acc_r[62:0], c[0]};
              end
            end
          end else begin
            err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_INVALID);
          end
        end
        rilp_pkg::KIND_OCT: begin
          if ((c >= rilp_pkg::CH_0) && (c <= rilp_pkg::CH_7)) begin
            if (err_r == rilp_pkg::ST_OK) begin
              if ((acc_r & rilp_pkg::OCT_GUARD) != '0) begin
                err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_OVERFLOW);
              end else begin
                acc_nxt = {acc_r[60:0], c[2:0]};
              end
            end
          end else begin
            err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_INVALID);
          end
        end
        default: begin
          if (is_dec) begin
            if (err_r == rilp_pkg::ST_OK) begin
              if ((acc_r > rilp_pkg::DEC_LIMIT) ||
                  ((acc_r == rilp_pkg::DEC_LIMIT) && (c > rilp_pkg::CH_5))) begin
                err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_OVERFLOW);
              end else begin
                acc_nxt = acc_x10 + {60'd0, c[3:0]};
              end
            end
          end else if ((mode_r == rilp_pkg::KIND_DEC) &&
                       (c == rilp_pkg::CH_DOT || c == rilp_pkg::CH_E)) begin
            err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_NONINT);
          end else begin
            err_nxt = rilp_pkg::raise_err(err_r, rilp_pkg::ST_INVALID);
          end
        end
      endcase
    end
  end

  // a non-final character always advances, the final one needs a free output slot
  assign adv  = item_valid && (!item.last_char || out_free);
  assign fire = adv && item.last_char;

  assign res.kind   = mode_nxt;
  assign res.value  = (err_nxt == rilp_pkg::ST_OK) ? acc_nxt : '0;
  assign res.status = err_nxt;

  // literal state, cleared after the final character
  always_ff @(posedge clk) begin
    if (!rst_n || fire) begin
      acc_r   <= '0;
      pos_r   <= '0;
      mode_r  <= rilp_pkg::KIND_DEC;
      first_r <= '0;
      err_r   <= rilp_pkg::ST_OK;
    end else if (adv) begin
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: design/rilp_out_stage.sv
module rilp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rilp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_literal_kind,
  output logic [63:0]       out_literal_value,
  output logic [1:0]        out_parse_status
);

  logic              valid_r;
  rilp_pkg::result_t res_r;

  // slot can take a new result when empty or draining this cycle
  assign out_free          = !valid_r || !out_stall;
  assign out_valid         = valid_r;
  assign out_literal_kind  = res_r.kind;
  assign out_literal_value = res_r.value;
  assign out_parse_status  = res_r.status;

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule

FILE: design/radix_integer_literal_parser.sv
// Parses one integer literal fed one character per transfer, last character flagged.
// Lowercase prefixes 0x, 0b, 0o and 0d select hex, binary, octal and explicit decimal;
// no prefix means plain decimal. One result transfer follows each final character with
// kind, 64-bit value (zero unless status is ok) and status (invalid digit, overflow, or
// non-integer for '.' or 'e' in plain decimal). Throughput is one character per cycle:
// each character passes an input register and one accumulate step (shift-or, or a
// times-ten add with a 64-bit compare); a result is offered from the result register
// after its final character's step, and only a stalled result register holds input off.
module radix_integer_literal_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_literal_kind,
  output logic [63:0] out_literal_value,
  output logic [1:0]  out_parse_status
);

  logic               item_valid;
  rilp_pkg::in_item_t item;
  logic               adv;
  logic               fire;
  logic               out_free;
  rilp_pkg::result_t  res;

  // input register
  rilp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .adv          (adv),
    .item_valid   (item_valid),
    .item         (item)
  );

  // character step and literal state
  rilp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .adv        (adv),
    .fire       (fire),
    .res        (res)
  );

  // result register
  rilp_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .res               (res),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_literal_kind  (out_literal_kind),
    .out_literal_value (out_literal_value),
    .out_parse_status  (out_parse_status)
  );

endmodule

FILE: tb/radix_integer_literal_parser_tb.sv
`timescale 1ns / 1ps

module radix_integer_literal_parser_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CASE_BIT = 8'h20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_last_char;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_literal_kind;
  logic [63:0] out_literal_value;
  logic [1:0]  out_parse_status;

  // parser state as the block should hold it
  logic [63:0]       lit_acc;
  int                lit_pos;
  rilp_pkg::kind_t   lit_kind;
  logic [7:0]        lit_first;
  rilp_pkg::status_t lit_err;

  rilp_pkg::result_t expected_literals[$];
  rilp_pkg::result_t seen_want;
  logic [7:0]        lit_buf[$];

  int mismatches = 0;
  int chars_sent = 0;
  int literals_checked = 0;
  int idle_cycles = 0;
  int results_by_kind[0:7];
  int results_by_status[0:3];

  // sender and receiver pacing
  int burst_left = 0;
  bit sender_eager = 1'b0;
  int hold_request = 0;
  int stall_stretch = 0;
  int stall_mode = 0;

  radix_integer_literal_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_literal_kind  (out_literal_kind),
    .out_literal_value (out_literal_value),
    .out_parse_status  (out_parse_status)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic clear_literal();
    lit_acc = '0;
    lit_pos = 0;
    lit_kind = rilp_pkg::KIND_DEC;
    lit_first = '0;
    lit_err = rilp_pkg::ST_OK;
  endtask

  function automatic int status_rank(input rilp_pkg::status_t s);
    case (s)
      rilp_pkg::ST_INVALID:  return 3;
      rilp_pkg::ST_NONINT:   return 2;
      rilp_pkg::ST_OVERFLOW: return 1;
      default:               return 0;
    endcase
  endfunction

  // stronger error wins, weaker never overrides
  function automatic rilp_pkg::status_t worse_status(input rilp_pkg::status_t cur,
                                                     input rilp_pkg::status_t e);
    return (status_rank(e) > status_rank(cur)) ? e : cur;
  endfunction

  task automatic shift_digit(input int n, input logic [63:0] guard, input logic [63:0] d);
    if (lit_err != rilp_pkg::ST_OK) return;
    if ((lit_acc & guard) != 0) begin
      lit_err = worse_status(lit_err, rilp_pkg::ST_OVERFLOW);
    end else begin
      lit_acc = (lit_acc << n) | d;
    end
  endtask

  task automatic accumulate_digit(input logic [7:0] c);
    logic        is_dec;
    logic [63:0] d;
    is_dec = (c >= rilp_pkg::CH_0) && (c <= rilp_pkg::CH_9);
    d = {56'd0, 8'(c - rilp_pkg::CH_0)};
    case (lit_kind)
      rilp_pkg::KIND_HEX: begin
        if (is_dec) begin
          shift_digit(4, rilp_pkg::HEX_GUARD, d);
        end else if (c >= rilp_pkg::CH_A && c <= rilp_pkg::CH_F) begin
          shift_digit(4, rilp_pkg::HEX_GUARD, {56'd0, 8'(c - rilp_pkg::CH_A + 8'd10)});
        end else begin
          lit_err = worse_status(lit_err, rilp_pkg::ST_INVALID);
        end
      end
      rilp_pkg::KIND_BIN: begin
        if (c == rilp_pkg::CH_0 || c == rilp_pkg::CH_1) begin
          shift_digit(1, rilp_pkg::BIN_GUARD, d);
        end else begin
          lit_err = worse_status(lit_err, rilp_pkg::ST_INVALID);
        end
      end
      rilp_pkg::KIND_OCT: begin
        if (is_dec && c <= rilp_pkg::CH_7) begin
          shift_digit(3, rilp_pkg::OCT_GUARD, d);
        end else begin
          lit_err = worse_status(lit_err, rilp_pkg::ST_INVALID);
        end
      end
      default: begin
        if (is_dec) begin
          // times ten plus digit, limited to 2^64-1
          if (lit_err == rilp_pkg::ST_OK) begin
            if (lit_acc > rilp_pkg::DEC_LIMIT ||
                (lit_acc == rilp_pkg::DEC_LIMIT &&
                 d > {56'd0, 8'(rilp_pkg::CH_5 - rilp_pkg::CH_0)})) begin
              lit_err = worse_status(lit_err, rilp_pkg::ST_OVERFLOW);
            end else begin
              lit_acc = lit_acc * 64'd10 + d;
            end
          end
        end else if (lit_kind == rilp_pkg::KIND_DEC &&
                     (c == rilp_pkg::CH_DOT || c == rilp_pkg::CH_E)) begin
          lit_err = worse_status(lit_err, rilp_pkg::ST_NONINT);
        end else begin
          lit_err = worse_status(lit_err, rilp_pkg::ST_INVALID);
        end
      end
    endcase
  endtask

  task automatic predict_char(input logic [7:0] c, input logic is_last);
    rilp_pkg::result_t r;
    if (lit_pos == 0) lit_first = c;
    // second character after a leading zero may select the radix
    if (lit_pos == 1 && lit_first == rilp_pkg::CH_0 && lit_kind == rilp_pkg::KIND_DEC &&
        lit_err == rilp_pkg::ST_OK &&
        (c == rilp_pkg::CH_X || c == rilp_pkg::CH_B ||
         c == rilp_pkg::CH_O || c == rilp_pkg::CH_D)) begin
      case (c)
        rilp_pkg::CH_X: lit_kind = rilp_pkg::KIND_HEX;
        rilp_pkg::CH_B: lit_kind = rilp_pkg::KIND_BIN;
        rilp_pkg::CH_O: lit_kind = rilp_pkg::KIND_OCT;
        default:        lit_kind = rilp_pkg::KIND_DEC_EXPL;
      endcase
      lit_acc = '0;
    end else begin
      accumulate_digit(c);
    end
    if (lit_pos < 3) lit_pos++;
    if (is_last) begin
      r.kind = lit_kind;
      r.value = (lit_err == rilp_pkg::ST_OK) ? lit_acc : '0;
      r.status = lit_err;
      expected_literals.push_back(r);
      clear_literal();
    end
  endtask

  // ---------------------------------------------------------------- literal builders

  function automatic logic [63:0] radix_of(input rilp_pkg::kind_t k);
    case (k)
      rilp_pkg::KIND_HEX: return 64'd16;
      rilp_pkg::KIND_BIN: return 64'd2;
      rilp_pkg::KIND_OCT: return 64'd8;
      default:            return 64'd10;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input logic [63:0] d);
    return (d < 64'd10) ? rilp_pkg::CH_0 + d[7:0] : rilp_pkg::CH_A + d[7:0] - 8'd10;
  endfunction

  // one random digit that is valid in the given radix
  function automatic logic [7:0] random_digit(input rilp_pkg::kind_t k);
    logic [63:0] d;
    d = 64'($urandom_range(0, 32'(radix_of(k) - 64'd1)));
    return digit_char(d);
  endfunction

  function automatic logic [7:0] prefix_char(input rilp_pkg::kind_t k);
    case (k)
      rilp_pkg::KIND_HEX: return rilp_pkg::CH_X;
      rilp_pkg::KIND_BIN: return rilp_pkg::CH_B;
      rilp_pkg::KIND_OCT: return rilp_pkg::CH_O;
      default:            return rilp_pkg::CH_D;
    endcase
  endfunction

  function automatic logic [63:0] pick_value(input bit near_top);
    if (near_top) begin
      case ($urandom_range(0, 3))
        0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
        1: return rilp_pkg::DEC_LIMIT - 64'd3 + 64'($urandom_range(0, 6));
        2: begin
          case ($urandom_range(0, 2))
            0: return ~rilp_pkg::HEX_GUARD - 64'($urandom_range(0, 3));
            1: return ~rilp_pkg::OCT_GUARD - 64'($urandom_range(0, 3));
            default: return ~rilp_pkg::BIN_GUARD - 64'($urandom_range(0, 3));
          endcase
        end
        default: return 64'h1 << $urandom_range(58, 63);
      endcase
    end
    case ($urandom_range(0, 6))
      0: return 64'($urandom_range(0, 9));
      1: return 64'($urandom_range(0, 4095));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: return {$urandom, $urandom};
      4: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom} >> $urandom_range(32, 63);
    endcase
  endfunction

  task automatic append_value(input rilp_pkg::kind_t k, input logic [63:0] v);
    logic [7:0]  digs[$];
    logic [63:0] r;
    r = radix_of(k);
    do begin
      digs.push_front(digit_char(v % r));
      v = v / r;
    end while (v != 0);
    foreach (digs[i]) lit_buf.push_back(digs[i]);
  endtask

  // well-formed literal with random content, optionally around the 64-bit edge
  task automatic build_literal(input rilp_pkg::kind_t k, input bit near_top);
    int nz;
    lit_buf.delete();
    if (k != rilp_pkg::KIND_DEC) begin
      lit_buf.push_back(rilp_pkg::CH_0);
      lit_buf.push_back(prefix_char(k));
      if ($urandom_range(0, 9) == 0) return;
    end
    nz = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    repeat (nz) lit_buf.push_back(rilp_pkg::CH_0);
    append_value(k, pick_value(near_top));
    if ($urandom_range(0, near_top ? 1 : 4) == 0) begin
      repeat ($urandom_range(1, 2)) lit_buf.push_back(random_digit(k));
    end else if ($urandom_range(0, 3) == 0) begin
      lit_buf[lit_buf.size() - 1] = random_digit(k);
    end
  endtask

  task automatic break_literal(input rilp_pkg::kind_t k);
    int p;
    p = $urandom_range(0, lit_buf.size() - 1);
    case ($urandom_range(0, 5))
      0: lit_buf.insert(p, rilp_pkg::CH_DOT);
      1: lit_buf.insert(p, rilp_pkg::CH_E);
      2: lit_buf[p] = 8'($urandom_range(0, 255));
      3: begin
        if (k != rilp_pkg::KIND_DEC) begin
          lit_buf[1] = lit_buf[1] - CASE_BIT;
        end else begin
          lit_buf.insert(0, ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
        end
      end
      4: lit_buf.insert(p, ($urandom_range(0, 1) != 0) ? CH_G : CH_G - CASE_BIT);
      default: lit_buf.insert(p, 8'($urandom_range(128, 255)));
    endcase
  endtask

  task automatic build_noise();
    lit_buf.delete();
    repeat ($urandom_range(1, 4)) begin
      lit_buf.push_back(8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) :
                           $urandom_range(CH_PLUS, 8'h7A)));
    end
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    if (!sender_eager) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, is_last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_buf.size(); i++) begin
      send_char(lit_buf[i], i == lit_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    lit_buf.delete();
    for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
    send_literal();
  endtask

  task automatic send_byte(input logic [7:0] c);
    lit_buf.delete();
    lit_buf.push_back(c);
    send_literal();
  endtask

  // sender pauses until every outstanding result has been checked
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_literals.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_prefixes();
    send_text("0x");
    send_text("0b1");
    send_text("0o7");
    send_text("0d9");
    send_text("0");
    send_text("9");
  endtask

  task automatic test_malformed();
    send_text("1.");
    send_text("0X");
    send_text(".-");
    send_text("0be");
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_limit_values();
    int stop_at;
    stop_at = chars_sent + 300;
    while (chars_sent < stop_at) begin
      build_literal(rilp_pkg::kind_t'($urandom_range(0, 4)), 1'b1);
      send_literal();
    end
  endtask

  // long output hold while the sender keeps offering characters
  task automatic test_backpressure();
    int stop_at;
    stop_at = chars_sent + 60;
    sender_eager = 1'b1;
    hold_request = 300;
    while (chars_sent < stop_at) begin
      build_literal(rilp_pkg::kind_t'($urandom_range(0, 4)), 1'b0);
      send_literal();
    end
    sender_eager = 1'b0;
  endtask

  task automatic test_random_literals();
    int              stop_at;
    int              choice;
    rilp_pkg::kind_t k;
    stop_at = chars_sent + 700;
    while (chars_sent < stop_at) begin
      choice = $urandom_range(0, 99);
      k = rilp_pkg::kind_t'($urandom_range(0, 4));
      if (choice < 70) begin
        build_literal(k, $urandom_range(0, 9) == 0);
      end else if (choice < 85) begin
        build_literal(k, 1'b0);
        break_literal(k);
      end else begin
        build_noise();
      end
      send_literal();
    end
  endtask

  // ---------------------------------------------------------------- result checking

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_literals.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d value %0h status %0d",
                 $time, out_literal_kind, out_literal_value, out_parse_status);
        mismatches++;
      end else begin
        seen_want = expected_literals.pop_front();
        literals_checked++;
        results_by_kind[out_literal_kind]++;
        results_by_status[out_parse_status]++;
        if (out_literal_kind !== seen_want.kind) begin
          $display("%0t: literal_kind mismatch, expected %0d, actual %0d",
                   $time, seen_want.kind, out_literal_kind);
          mismatches++;
        end
        if (out_literal_value !== seen_want.value) begin
          $display("%0t: literal_value mismatch, expected %0h, actual %0h",
                   $time, seen_want.value, out_literal_value);
          mismatches++;
        end
        if (out_parse_status !== seen_want.status) begin
          $display("%0t: parse_status mismatch, expected %0d, actual %0d",
                   $time, seen_want.status, out_parse_status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        hold_request = hold_request - 1;
      end else begin
        if (stall_stretch == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_stretch = $urandom_range(20, 200);
        end
        stall_stretch--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= (stall_stretch % 4 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    in_last_char = 1'b0;
    foreach (results_by_kind[i]) results_by_kind[i] = 0;
    foreach (results_by_status[i]) results_by_status[i] = 0;
    clear_literal();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_prefixes();
    test_malformed();
    wait_drained();
    test_limit_values();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_literals();
    wait_drained();

    $display("Covered %0d characters, %0d literals; kinds dec/hex/bin/oct/0d = %0d/%0d/%0d/%0d/%0d",
             chars_sent, literals_checked, results_by_kind[0], results_by_kind[1],
             results_by_kind[2], results_by_kind[3], results_by_kind[4]);
    $display("Statuses ok/invalid/overflow/non-integer = %0d/%0d/%0d/%0d, incl. long output hold",
             results_by_status[0], results_by_status[1], results_by_status[2],
             results_by_status[3]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rilp_pkg.sv
design/rilp_in_stage.sv
design/rilp_core.sv
design/rilp_out_stage.sv
design/radix_integer_literal_parser.sv
tb/radix_integer_literal_parser_tb.sv
